[hdl/ecal_pkg.sv]
// Shared constants, widths and the month table for the epoch-to-calendar core.
// Used by every module under hdl except ecal_fifo; depends on nothing else.
package ecal_pkg;

    // Defaults and fixed field widths
    localparam int STAMP_BITS_DEF = 47;
    localparam int OFFSET_W       = 28;
    localparam int ADDR_W         = 3;
    localparam int DATA_W         = 32;

    localparam int YEAR_W   = 13;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MIN_W    = 6;
    localparam int SEC_W    = 6;
    localparam int MS_W     = 10;

    // Register index decoded from paddr
    localparam logic REG_TZ_OFFSET = 1'b0;

    // Calendar and clock constants
    localparam int MS_PER_DAY     = 86400000;
    localparam int MS_PER_SEC     = 1000;
    localparam int SIXTY          = 60;
    localparam int HOURS_PER_DAY  = 24;
    localparam int ERA_DAYS       = 146097;
    localparam int CENT_DAYS      = 36524;
    localparam int QUAD_DAYS      = 1461;
    localparam int YEAR_DAYS      = 365;
    localparam int CENT_YEARS     = 100;
    localparam int YEARS_PER_ERA  = 400;
    // Days from 0000-03-01 to 1970-01-01
    localparam int DAYS_TO_EPOCH  = 719468;

    // Divider geometry: divisor width and quotient bits per cycle
    localparam int DIVR_W    = $clog2(MS_PER_DAY);
    localparam int DIV_STEPS = 4;

    // Round a width up to a whole number of divider cycles
    function automatic int pad_w(input int w);
        return ((w + DIV_STEPS - 1) / DIV_STEPS) * DIV_STEPS;
    endfunction

    // First day of each month in a year that starts on March 1
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] v;
        case (mp)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd31;
            4'd2:    v = 9'd61;
            4'd3:    v = 9'd92;
            4'd4:    v = 9'd122;
            4'd5:    v = 9'd153;
            4'd6:    v = 9'd184;
            4'd7:    v = 9'd214;
            4'd8:    v = 9'd245;
            4'd9:    v = 9'd275;
            4'd10:   v = 9'd306;
            4'd11:   v = 9'd337;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

endpackage

[hdl/ecal_fifo.sv]
// Two-entry request queue between the front end and the date engine.
// Depends on nothing; the entry width comes from the instantiating module.
module ecal_fifo #(
    parameter int W = 76
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] din,
    input  logic         pop,
    output logic [W-1:0] dout,
    output logic         full,
    output logic         empty
);
    logic [W-1:0] mem_reg [2];
    logic         wr_ptr_reg;
    logic         rd_ptr_reg;
    logic [1:0]   cnt_reg;

    // Store pushed request
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    assign dout  = mem_reg[rd_ptr_reg];
    assign full  = (cnt_reg == 2'd2);
    assign empty = (cnt_reg == 2'd0);

endmodule

[hdl/ecal_front.sv]
// Front end: accepts a timestamp, applies the signed zone offset and saturates at zero.
// Depends on ecal_pkg; feeds ecal_fifo.
module ecal_front #(
    parameter int STAMP_BITS = ecal_pkg::STAMP_BITS_DEF
) (
    input  logic                                 start,
    output logic                                 busy,
    input  logic [STAMP_BITS-1:0]                timestamp_ms,
    input  logic signed [ecal_pkg::OFFSET_W-1:0] tz_offset_ms,
    input  logic                                 fifo_full,
    output logic                                 push,
    output logic [STAMP_BITS+ecal_pkg::OFFSET_W+1:0] entry
);
    import ecal_pkg::*;

    localparam int T_W = STAMP_BITS + 1;

    logic                neg;
    logic [OFFSET_W-1:0] mag;
    logic [T_W-1:0]      sum;
    logic [T_W:0]        diff;
    logic [T_W-1:0]      adj;

    // Split the offset into sign and magnitude
    assign neg = tz_offset_ms[OFFSET_W-1];
    assign mag = neg ? (~tz_offset_ms + 1'b1) : tz_offset_ms;

    // Add or subtract, clamp negative results to zero
    assign sum  = T_W'(timestamp_ms) + T_W'(mag);
    assign diff = {2'b00, timestamp_ms} - {1'b0, T_W'(mag)};
    assign adj  = neg ? (diff[T_W] ? '0 : diff[T_W-1:0]) : sum;

    assign busy  = fifo_full;
    assign push  = start && !fifo_full;
    assign entry = {adj, neg, mag};

endmodule

[hdl/ecal_div.sv]
// Iterative restoring divider, DIV_STEPS quotient bits per cycle.
// Depends on ecal_pkg; shared by all divisions in ecal_back.
module ecal_div #(
    parameter int NP    = 48,
    parameter int CNT_W = 4
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        load,
    input  logic [NP-1:0]               dividend,
    input  logic [CNT_W-1:0]            steps,
    input  logic [ecal_pkg::DIVR_W-1:0] divisor,
    output logic                        idle,
    output logic [NP-1:0]               quot,
    output logic [ecal_pkg::DIVR_W-1:0] rem
);
    import ecal_pkg::*;

    logic [NP-1:0]     sh_reg;
    logic [NP-1:0]     sh_next;
    logic [DIVR_W-1:0] rem_reg;
    logic [DIVR_W-1:0] rem_next;
    logic [DIVR_W-1:0] dvs_reg;
    logic [CNT_W-1:0]  cnt_reg;

    // Retire DIV_STEPS quotient bits, MSB first
    always_comb
    begin
        logic [DIVR_W:0] trial;
        rem_next = rem_reg;
        sh_next  = sh_reg;
        for (int i = 0; i < DIV_STEPS; i++)
        begin
            trial = {rem_next, sh_next[NP-1]};
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = DIVR_W'(trial - {1'b0, dvs_reg});
                sh_next  = {sh_next[NP-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DIVR_W-1:0];
                sh_next  = {sh_next[NP-2:0], 1'b0};
            end
        end
    end

    // Load operands or advance the division
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sh_reg  <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            sh_reg  <= sh_next;
            rem_reg <= rem_next;
        end
    end

    // Count remaining cycles
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (load)
        begin
            cnt_reg <= steps;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    assign idle = (cnt_reg == '0);
    assign quot = sh_reg;
    assign rem  = rem_reg;

endmodule

[hdl/ecal_back.sv]
// Date engine: runs the shared divider through time-of-day, era, four-year and offset splits,
// compares for the century, then resolves year, month and day. Depends on ecal_pkg, ecal_div.
module ecal_back #(
    parameter int STAMP_BITS = ecal_pkg::STAMP_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              fifo_empty,
    input  logic [STAMP_BITS+ecal_pkg::OFFSET_W+1:0] entry,
    output logic                              pop,
    output logic                              done,
    output logic [ecal_pkg::YEAR_W-1:0]       year,
    output logic [ecal_pkg::MONTH_W-1:0]      month,
    output logic [ecal_pkg::DAY_W-1:0]        day,
    output logic [ecal_pkg::HOUR_W-1:0]       hour,
    output logic [ecal_pkg::MIN_W-1:0]        minute,
    output logic [ecal_pkg::SEC_W-1:0]        second,
    output logic [ecal_pkg::MS_W-1:0]         millisecond,
    output logic                              offset_negative,
    output logic [ecal_pkg::HOUR_W-1:0]       offset_hours,
    output logic [ecal_pkg::MIN_W-1:0]        offset_minutes,
    output logic [ecal_pkg::SEC_W-1:0]        offset_seconds,
    output logic [ecal_pkg::MS_W-1:0]         offset_millis
);
    import ecal_pkg::*;

    // Derived widths
    localparam int T_W    = STAMP_BITS + 1;
    localparam int NP     = pad_w(T_W);
    localparam int CNT_W  = $clog2(NP / DIV_STEPS + 1);
    localparam int DCNT_W = T_W - ($clog2(MS_PER_DAY) - 1);
    localparam int EPO_W  = $clog2(DAYS_TO_EPOCH);
    localparam int Z_W    = ((DCNT_W > EPO_W) ? DCNT_W : EPO_W) + 1;
    localparam int ZP     = pad_w(Z_W);
    localparam int ERA_W  = Z_W - ($clog2(ERA_DAYS) - 1);
    localparam int YR_W   = ERA_W + 9;
    localparam int MSD_PW = pad_w(DIVR_W);
    localparam int SOD_PW = pad_w(17);
    localparam int MOD_PW = pad_w(11);
    localparam int R1_PW  = pad_w(16);
    localparam int MAG_PW = pad_w(OFFSET_W);
    localparam int OMS_PW = pad_w(18);
    localparam int OMN_PW = pad_w(12);

    // Sequencer states
    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_DAY  = 4'd1;
    localparam logic [3:0] ST_SEC  = 4'd2;
    localparam logic [3:0] ST_MIN  = 4'd3;
    localparam logic [3:0] ST_HOUR = 4'd4;
    localparam logic [3:0] ST_ERA  = 4'd5;
    localparam logic [3:0] ST_CENT = 4'd6;
    localparam logic [3:0] ST_Q4   = 4'd7;
    localparam logic [3:0] ST_OMS  = 4'd8;
    localparam logic [3:0] ST_OSEC = 4'd9;
    localparam logic [3:0] ST_OMIN = 4'd10;
    localparam logic [3:0] ST_FIN1 = 4'd11;
    localparam logic [3:0] ST_FIN2 = 4'd12;

    logic [3:0]          state_reg;
    logic [3:0]          state_next;

    logic [T_W-1:0]      ent_t;
    logic                ent_neg;
    logic [OFFSET_W-1:0] ent_mag;

    logic                div_load;
    logic [NP-1:0]       div_a;
    logic [CNT_W-1:0]    div_steps;
    logic [DIVR_W-1:0]   div_dvs;
    logic                div_idle;
    logic [NP-1:0]       div_quot;
    logic [DIVR_W-1:0]   div_rem;

    logic                neg_reg;
    logic [OFFSET_W-1:0] mag_reg;
    logic [DCNT_W-1:0]   days_reg;
    logic [MS_W-1:0]     ms_reg;
    logic [SEC_W-1:0]    sec_reg;
    logic [MIN_W-1:0]    min_reg;
    logic [HOUR_W-1:0]   hour_reg;
    logic [ERA_W-1:0]    era_reg;
    logic [17:0]         doe_reg;
    logic [1:0]          c_reg;
    logic [4:0]          q4_reg;
    logic [10:0]         rem2_reg;
    logic [MS_W-1:0]     off_ms_reg;
    logic [SEC_W-1:0]    off_sec_reg;
    logic [MIN_W-1:0]    off_min_reg;
    logic [HOUR_W-1:0]   off_hr_reg;
    logic [8:0]          yoe_reg;
    logic [8:0]          doy_reg;
    logic [YEAR_W-1:0]   year_reg;
    logic [MONTH_W-1:0]  month_reg;
    logic [DAY_W-1:0]    day_reg;
    logic                done_reg;

    logic [Z_W-1:0]      z_val;
    logic [1:0]          cent;
    logic [15:0]         rem1;
    logic [5:0]          off_hr_raw;
    logic [HOUR_W-1:0]   off_hr_mod;
    logic [1:0]          y1;
    logic [8:0]          doy_val;
    logic [8:0]          yoe_val;
    logic [3:0]          mp;
    logic [DAY_W-1:0]    dd;
    logic [MONTH_W-1:0]  mm;
    logic                jan_feb;
    logic [YR_W-1:0]     year_full;

    assign ent_t   = entry[T_W+OFFSET_W:OFFSET_W+1];
    assign ent_neg = entry[OFFSET_W];
    assign ent_mag = entry[OFFSET_W-1:0];

    ecal_div #(
        .NP    (NP),
        .CNT_W (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (div_load),
        .dividend (div_a),
        .steps    (div_steps),
        .divisor  (div_dvs),
        .idle     (div_idle),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    // Day count shifted to the March-based era origin
    assign z_val = Z_W'(days_reg) + Z_W'(DAYS_TO_EPOCH);

    // Century within the era, last century absorbs the extra leap day
    always_comb
    begin
        if (doe_reg >= 18'(3 * CENT_DAYS))
        begin
            cent = 2'd3;
        end
        else if (doe_reg >= 18'(2 * CENT_DAYS))
        begin
            cent = 2'd2;
        end
        else if (doe_reg >= 18'(CENT_DAYS))
        begin
            cent = 2'd1;
        end
        else
        begin
            cent = 2'd0;
        end
        rem1 = 16'(doe_reg - 18'(cent) * 18'(CENT_DAYS));
    end

    // Offset hours wrap at a full day
    assign off_hr_raw = div_quot[5:0];
    assign off_hr_mod = (off_hr_raw >= 6'(HOURS_PER_DAY)) ?
                        HOUR_W'(off_hr_raw - 6'(HOURS_PER_DAY)) : HOUR_W'(off_hr_raw);

    // Year within the four-year group, last year absorbs the leap day
    always_comb
    begin
        if (rem2_reg >= 11'(3 * YEAR_DAYS))
        begin
            y1 = 2'd3;
        end
        else if (rem2_reg >= 11'(2 * YEAR_DAYS))
        begin
            y1 = 2'd2;
        end
        else if (rem2_reg >= 11'(YEAR_DAYS))
        begin
            y1 = 2'd1;
        end
        else
        begin
            y1 = 2'd0;
        end
        doy_val = 9'(rem2_reg - 11'(y1) * 11'(YEAR_DAYS));
        yoe_val = 9'(c_reg) * 9'(CENT_YEARS) + {2'b00, q4_reg, 2'b00} + 9'(y1);
    end

    // Month, day and final year from the March-based day of year
    always_comb
    begin
        mp = 4'd0;
        for (int i = 1; i < 12; i++)
        begin
            if (doy_reg >= month_start(4'(i)))
            begin
                mp = 4'(i);
            end
        end
        dd        = DAY_W'(doy_reg - month_start(mp)) + 1'b1;
        jan_feb   = (mp >= 4'd10);
        mm        = jan_feb ? (mp - 4'd9) : (mp + 4'd3);
        year_full = YR_W'(era_reg) * YR_W'(YEARS_PER_ERA) + YR_W'(yoe_reg) + YR_W'(jan_feb);
    end

    // Sequence the divider and pick its operands
    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        div_load   = 1'b0;
        div_a      = '0;
        div_steps  = '0;
        div_dvs    = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!fifo_empty)
                begin
                    pop        = 1'b1;
                    div_load   = 1'b1;
                    div_a      = NP'(ent_t);
                    div_steps  = CNT_W'(NP / DIV_STEPS);
                    div_dvs    = DIVR_W'(MS_PER_DAY);
                    state_next = ST_DAY;
                end
            end
            ST_DAY:
            begin
                if (div_idle)
                begin
                    div_load   = 1'b1;
                    div_a      = NP'(div_rem) << (NP - MSD_PW);
                    div_steps  = CNT_W'(MSD_PW / DIV_STEPS);
                    div_dvs    = DIVR_W'(MS_PER_SEC);
                    state_next = ST_SEC;
                end
            end
            ST_SEC:
            begin
                if (div_idle)
                begin
                    div_load   = 1'b1;
                    div_a      = NP'(div_quot[16:0]) << (NP - SOD_PW);
                    div_steps  = CNT_W'(SOD_PW / DIV_STEPS);
                    div_dvs    = DIVR_W'(SIXTY);
                    state_next = ST_MIN;
                end
            end
            ST_MIN:
            begin
                if (div_idle)
                begin
                    div_load   = 1'b1;
                    div_a      = NP'(div_quot[10:0]) << (NP - MOD_PW);
                    div_steps  = CNT_W'(MOD_PW / DIV_STEPS);
                    div_dvs    = DIVR_W'(SIXTY);
                    state_next = ST_HOUR;
                end
            end
            ST_HOUR:
            begin
                if (div_idle)
                begin
                    div_load   = 1'b1;
                    div_a      = NP'(z_val) << (NP - ZP);
                    div_steps  = CNT_W'(ZP / DIV_STEPS);
                    div_dvs    = DIVR_W'(ERA_DAYS);
                    state_next = ST_ERA;
                end
            end
            ST_ERA:
            begin
                if (div_idle)
                begin
                    state_next = ST_CENT;
                end
            end
            ST_CENT:
            begin
                div_load   = 1'b1;
                div_a      = NP'(rem1) << (NP - R1_PW);
                div_steps  = CNT_W'(R1_PW / DIV_STEPS);
                div_dvs    = DIVR_W'(QUAD_DAYS);
                state_next = ST_Q4;
            end
            ST_Q4:
            begin
                if (div_idle)
                begin
                    div_load   = 1'b1;
                    div_a      = NP'(mag_reg) << (NP - MAG_PW);
                    div_steps  = CNT_W'(MAG_PW / DIV_STEPS);
                    div_dvs    = DIVR_W'(MS_PER_SEC);
                    state_next = ST_OMS;
                end
            end
            ST_OMS:
            begin
                if (div_idle)
                begin
                    div_load   = 1'b1;
                    div_a      = NP'(div_quot[17:0]) << (NP - OMS_PW);
                    div_steps  = CNT_W'(OMS_PW / DIV_STEPS);
                    div_dvs    = DIVR_W'(SIXTY);
                    state_next = ST_OSEC;
                end
            end
            ST_OSEC:
            begin
                if (div_idle)
                begin
                    div_load   = 1'b1;
                    div_a      = NP'(div_quot[11:0]) << (NP - OMN_PW);
                    div_steps  = CNT_W'(OMN_PW / DIV_STEPS);
                    div_dvs    = DIVR_W'(SIXTY);
                    state_next = ST_OMIN;
                end
            end
            ST_OMIN:
            begin
                if (div_idle)
                begin
                    state_next = ST_FIN1;
                end
            end
            ST_FIN1:
            begin
                state_next = ST_FIN2;
            end
            ST_FIN2:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Capture the popped offset, divider results as each split completes, and the date fields
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (!fifo_empty)
                begin
                    neg_reg <= ent_neg;
                    mag_reg <= ent_mag;
                end
            end
            ST_DAY:
            begin
                if (div_idle)
                begin
                    days_reg <= div_quot[DCNT_W-1:0];
                end
            end
            ST_SEC:
            begin
                if (div_idle)
                begin
                    ms_reg <= div_rem[MS_W-1:0];
                end
            end
            ST_MIN:
            begin
                if (div_idle)
                begin
                    sec_reg <= div_rem[SEC_W-1:0];
                end
            end
            ST_HOUR:
            begin
                if (div_idle)
                begin
                    min_reg  <= div_rem[MIN_W-1:0];
                    hour_reg <= div_quot[HOUR_W-1:0];
                end
            end
            ST_ERA:
            begin
                if (div_idle)
                begin
                    era_reg <= div_quot[ERA_W-1:0];
                    doe_reg <= div_rem[17:0];
                end
            end
            ST_CENT:
            begin
                c_reg <= cent;
            end
            ST_Q4:
            begin
                if (div_idle)
                begin
                    q4_reg   <= div_quot[4:0];
                    rem2_reg <= div_rem[10:0];
                end
            end
            ST_OMS:
            begin
                if (div_idle)
                begin
                    off_ms_reg <= div_rem[MS_W-1:0];
                end
            end
            ST_OSEC:
            begin
                if (div_idle)
                begin
                    off_sec_reg <= div_rem[SEC_W-1:0];
                end
            end
            ST_OMIN:
            begin
                if (div_idle)
                begin
                    off_min_reg <= div_rem[MIN_W-1:0];
                    off_hr_reg  <= off_hr_mod;
                end
            end
            ST_FIN1:
            begin
                yoe_reg <= yoe_val;
                doy_reg <= doy_val;
            end
            ST_FIN2:
            begin
                year_reg  <= year_full[YEAR_W-1:0];
                month_reg <= mm;
                day_reg   <= dd;
            end
            default:
            begin
            end
        endcase
    end

    // Advance state and pulse the result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ST_FIN2);
        end
    end

    assign done            = done_reg;
    assign year            = year_reg;
    assign month           = month_reg;
    assign day             = day_reg;
    assign hour            = hour_reg;
    assign minute          = min_reg;
    assign second          = sec_reg;
    assign millisecond     = ms_reg;
    assign offset_negative = neg_reg;
    assign offset_hours    = off_hr_reg;
    assign offset_minutes  = off_min_reg;
    assign offset_seconds  = off_sec_reg;
    assign offset_millis   = off_ms_reg;

endmodule

[hdl/epoch_ms_to_calendar_fields_core.sv]
// Top level of the epoch-to-calendar core: zone offset register, front end,
// request queue and date engine. Depends on ecal_pkg, ecal_front, ecal_fifo, ecal_back.
//
// Usage:
//   Write the signed zone offset (milliseconds) over the APB port at byte address 0;
//   writes pass through the setup and access phases, pready is always high. Reads return it.
//   Drive timestamp_ms with start high; the request is taken at the clock edge where
//   start is high and busy is low. busy rises only when the two-entry queue is full.
//   Each request yields exactly one result: all result ports are valid for the single
//   cycle in which done is high. The receiver cannot stall; capture on done.
// Operation:
//   The date engine runs one shared divider at 4 quotient bits per cycle through nine
//   splits in turn, each dividend padded to a multiple of 4 bits. Requests are served
//   one after another; the queue lets two more wait meanwhile.
// Reset:
//   rst_n clears the queue, the sequencer and the offset register (offset 0).
module epoch_ms_to_calendar_fields_core #(
    parameter int STAMP_BITS = ecal_pkg::STAMP_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // APB configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ecal_pkg::ADDR_W-1:0]   paddr,
    input  logic [ecal_pkg::DATA_W-1:0]   pwdata,
    output logic [ecal_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    // Request
    input  logic                          start,
    output logic                          busy,
    input  logic [STAMP_BITS-1:0]         timestamp_ms,
    // Result
    output logic                          done,
    output logic [ecal_pkg::YEAR_W-1:0]   year,
    output logic [ecal_pkg::MONTH_W-1:0]  month,
    output logic [ecal_pkg::DAY_W-1:0]    day,
    output logic [ecal_pkg::HOUR_W-1:0]   hour,
    output logic [ecal_pkg::MIN_W-1:0]    minute,
    output logic [ecal_pkg::SEC_W-1:0]    second,
    output logic [ecal_pkg::MS_W-1:0]     millisecond,
    output logic                          offset_negative,
    output logic [ecal_pkg::HOUR_W-1:0]   offset_hours,
    output logic [ecal_pkg::MIN_W-1:0]    offset_minutes,
    output logic [ecal_pkg::SEC_W-1:0]    offset_seconds,
    output logic [ecal_pkg::MS_W-1:0]     offset_millis
);
    import ecal_pkg::*;

    localparam int ENT_W = STAMP_BITS + 2 + OFFSET_W;

    logic signed [OFFSET_W-1:0] tz_reg;
    logic                       reg_sel;
    logic                       fifo_full;
    logic                       fifo_empty;
    logic                       push;
    logic                       pop;
    logic [ENT_W-1:0]           fe_entry;
    logic [ENT_W-1:0]           q_entry;

    // Decode register index from the top address bit
    assign reg_sel = (paddr[ADDR_W-1] == REG_TZ_OFFSET);

    // Hold the zone offset register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tz_reg <= '0;
        end
        else if (psel && penable && pwrite && pready && reg_sel)
        begin
            tz_reg <= pwdata[OFFSET_W-1:0];
        end
    end

    // Return the offset sign-extended, or zero at the other register index
    assign prdata = reg_sel ? {{(DATA_W - OFFSET_W){tz_reg[OFFSET_W-1]}}, tz_reg} : '0;
    assign pready = 1'b1;

    ecal_front #(
        .STAMP_BITS (STAMP_BITS)
    ) u_front (
        .start        (start),
        .busy         (busy),
        .timestamp_ms (timestamp_ms),
        .tz_offset_ms (tz_reg),
        .fifo_full    (fifo_full),
        .push         (push),
        .entry        (fe_entry)
    );

    ecal_fifo #(
        .W (ENT_W)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (fe_entry),
        .pop   (pop),
        .dout  (q_entry),
        .full  (fifo_full),
        .empty (fifo_empty)
    );

    ecal_back #(
        .STAMP_BITS (STAMP_BITS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .fifo_empty      (fifo_empty),
        .entry           (q_entry),
        .pop             (pop),
        .done            (done),
        .year            (year),
        .month           (month),
        .day             (day),
        .hour            (hour),
        .minute          (minute),
        .second          (second),
        .millisecond     (millisecond),
        .offset_negative (offset_negative),
        .offset_hours    (offset_hours),
        .offset_minutes  (offset_minutes),
        .offset_seconds  (offset_seconds),
        .offset_millis   (offset_millis)
    );

endmodule
